>>> sv/brtwo_pkg.sv
// Shared types, constants and tap weights of the binomial reduce-by-two column filter.
`default_nettype none

package brtwo_pkg;

  localparam int unsigned DefaultMaxColumn = 4096;
  localparam int unsigned DefaultSampleBits = 16;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned LENGTH_W    = 13;
  localparam int unsigned OUT_VALUE_W = 20;
  localparam int unsigned OUT_INDEX_W = 11;
  localparam int unsigned NUM_TAPS    = 5;
  localparam int unsigned WEIGHT_W    = 4;

  localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(5);
  localparam logic [LENGTH_W-1:0] LENGTH_MIN   = LENGTH_W'(5);

  // Weights scaled by 16.
  localparam logic [WEIGHT_W-1:0] W_EDGE_CENTRE    = 4'd11;
  localparam logic [WEIGHT_W-1:0] W_PRELAST_CENTRE = 4'd5;
  localparam logic [WEIGHT_W-1:0] W_CENTRE         = 4'd6;
  localparam logic [WEIGHT_W-1:0] W_NEAR           = 4'd4;
  localparam logic [WEIGHT_W-1:0] W_FAR            = 4'd1;

  typedef enum logic [2:0] {
    TAP_NONE,
    TAP_FIRST,
    TAP_MID,
    TAP_PRELAST,
    TAP_LAST_ODD,
    TAP_LAST_EVEN
  } tap_kind_e;

  typedef struct packed {
    tap_kind_e              kind;
    logic [OUT_INDEX_W-1:0] index;
  } tap_ctrl_t;

  typedef logic [NUM_TAPS-1:0][WEIGHT_W-1:0] tap_weights_t;

  // Tap 0 is the oldest sample of the window and tap 4 the newest.
  function automatic tap_weights_t tap_weights(tap_kind_e kind);
    tap_weights_t wt;
    wt = '0;
    unique case (kind)
      TAP_FIRST: begin
        wt[2] = W_EDGE_CENTRE;
        wt[3] = W_NEAR;
        wt[4] = W_FAR;
      end
      TAP_MID: begin
        wt[0] = W_FAR;
        wt[1] = W_NEAR;
        wt[2] = W_CENTRE;
        wt[3] = W_NEAR;
        wt[4] = W_FAR;
      end
      TAP_PRELAST: begin
        wt[1] = W_FAR;
        wt[2] = W_NEAR;
        wt[3] = W_CENTRE;
        wt[4] = W_PRELAST_CENTRE;
      end
      TAP_LAST_ODD: begin
        wt[2] = W_FAR;
        wt[3] = W_NEAR;
        wt[4] = W_EDGE_CENTRE;
      end
      TAP_LAST_EVEN: begin
        wt[1] = W_FAR;
        wt[2] = W_NEAR;
        wt[3] = W_EDGE_CENTRE;
      end
      default: begin
        wt = '0;
      end
    endcase
    return wt;
  endfunction

endpackage

`default_nettype wire

>>> sv/brtwo_pos.sv
// Column position counter and output decode for each accepted sample.
`default_nettype none

module brtwo_pos #(
  parameter int unsigned MaxColumn = brtwo_pkg::DefaultMaxColumn
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic [brtwo_pkg::LENGTH_W-1:0]  column_length_i,
  output brtwo_pkg::tap_ctrl_t                 ctrl_o
);

  localparam int unsigned PosW = $clog2(MaxColumn);
  localparam int unsigned LenW = $clog2(MaxColumn + 1);
  localparam int unsigned CmpW = (LenW > brtwo_pkg::LENGTH_W) ? LenW : brtwo_pkg::LENGTH_W;

  logic [PosW-1:0] pos_q, pos_d;
  logic [CmpW-1:0] cfg_ext;
  logic [LenW-1:0] len;
  logic [LenW-1:0] last_pos;
  logic [LenW-1:0] pre_last_pos;
  logic [LenW-1:0] pos_ext;
  logic [LenW:0]   half_len;
  logic            odd;
  logic            at_end;

  always_comb begin
    cfg_ext = CmpW'(column_length_i);
    if (cfg_ext < CmpW'(brtwo_pkg::LENGTH_MIN)) begin
      len = LenW'(brtwo_pkg::LENGTH_MIN);
    end else if (cfg_ext > CmpW'(MaxColumn)) begin
      len = LenW'(MaxColumn);
    end else begin
      len = LenW'(cfg_ext);
    end
  end

  assign odd          = len[0];
  assign last_pos     = len - LenW'(1);
  assign pre_last_pos = len - LenW'(2);
  assign half_len     = ({1'b0, len} + (LenW + 1)'(1)) >> 1;
  assign pos_ext      = LenW'(pos_q);
  assign at_end       = (pos_ext >= last_pos);

  always_comb begin
    ctrl_o.kind  = brtwo_pkg::TAP_NONE;
    ctrl_o.index = '0;
    if (at_end) begin
      if (pos_ext == last_pos) begin
        ctrl_o.kind  = odd ? brtwo_pkg::TAP_LAST_ODD : brtwo_pkg::TAP_LAST_EVEN;
        ctrl_o.index = brtwo_pkg::OUT_INDEX_W'(half_len - (LenW + 1)'(1));
      end
    end else if (odd && (pos_ext == pre_last_pos)) begin
      ctrl_o.kind  = brtwo_pkg::TAP_PRELAST;
      ctrl_o.index = brtwo_pkg::OUT_INDEX_W'(half_len - (LenW + 1)'(2));
    end else if (pos_q == PosW'(2)) begin
      ctrl_o.kind  = brtwo_pkg::TAP_FIRST;
      ctrl_o.index = '0;
    end else if ((pos_q >= PosW'(4)) && !pos_q[0]) begin
      ctrl_o.kind  = brtwo_pkg::TAP_MID;
      ctrl_o.index = brtwo_pkg::OUT_INDEX_W'((pos_q >> 1) - PosW'(1));
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      pos_d = at_end ? '0 : pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/brtwo_taps.sv
// Weighted sum of the five-sample window for the selected output kind.
`default_nettype none

module brtwo_taps #(
  parameter int unsigned SampleW = brtwo_pkg::SAMPLE_W
) (
  input  wire logic [brtwo_pkg::NUM_TAPS-1:0][SampleW-1:0] window_i,
  input  wire brtwo_pkg::tap_kind_e                        kind_i,
  output logic [brtwo_pkg::OUT_VALUE_W-1:0]                value_o
);

  localparam int unsigned SumW = SampleW + brtwo_pkg::WEIGHT_W;

  brtwo_pkg::tap_weights_t wt;
  logic [SumW-1:0]         sum;

  assign wt = brtwo_pkg::tap_weights(kind_i);

  always_comb begin
    sum = '0;
    for (int i = 0; i < brtwo_pkg::NUM_TAPS; i++) begin
      sum = sum + SumW'(window_i[i]) * SumW'(wt[i]);
    end
  end

  assign value_o = brtwo_pkg::OUT_VALUE_W'(sum);

endmodule

`default_nettype wire

>>> sv/binomial_reduce_by_two.sv
// Top level of the binomial reduce-by-two column filter.
// Takes one sample of a column per cycle, unless in_stall_o holds it off, and emits the
// column halved with the 1,4,6,4,1 binomial kernel, the edge outputs using 11,4,1 and,
// on odd lengths, the next-to-last output using 5,6,4,1; values are exact sums scaled
// by 16. Sustained rate is one sample per clock while the output is not stalled; a
// result passes through the window register and then the result register. The column
// length register may only be written while no transaction is in flight.
`default_nettype none

module binomial_reduce_by_two #(
  parameter int unsigned MaxColumn  = brtwo_pkg::DefaultMaxColumn,
  parameter int unsigned SampleBits = brtwo_pkg::DefaultSampleBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [brtwo_pkg::LENGTH_W-1:0]     cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [brtwo_pkg::SAMPLE_W-1:0]     sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [brtwo_pkg::OUT_VALUE_W-1:0]       out_value_o,
  output logic [brtwo_pkg::OUT_INDEX_W-1:0]       out_index_o,
  output logic                                    out_last_o
);

  localparam int unsigned SampleW =
    (SampleBits < brtwo_pkg::SAMPLE_W) ? SampleBits : brtwo_pkg::SAMPLE_W;

  logic [brtwo_pkg::LENGTH_W-1:0] column_length_q;

  logic [3:0][SampleW-1:0] hist_q;
  logic [SampleW-1:0]      sample_in;

  logic                                           win_valid_q;
  logic [brtwo_pkg::NUM_TAPS-1:0][SampleW-1:0]    win_q;
  brtwo_pkg::tap_ctrl_t                           win_ctrl_q;
  brtwo_pkg::tap_ctrl_t                           ctrl;

  logic                                out_valid_q;
  logic [brtwo_pkg::OUT_VALUE_W-1:0]   out_value_q;
  logic [brtwo_pkg::OUT_INDEX_W-1:0]   out_index_q;
  logic                                out_last_q;
  logic [brtwo_pkg::OUT_VALUE_W-1:0]   value;

  logic in_accept;
  logic out_ready;
  logic win_advance;
  logic win_emit;

  assign sample_in   = SampleW'(sample_i);
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign win_advance = win_valid_q && out_ready;
  assign in_stall_o  = win_valid_q && !out_ready;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign win_emit    = win_ctrl_q.kind != brtwo_pkg::TAP_NONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_length_q <= brtwo_pkg::LENGTH_RESET;
    end else if (cfg_we_i) begin
      column_length_q <= cfg_wdata_i;
    end
  end

  brtwo_pos #(
    .MaxColumn(MaxColumn)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .column_length_i(column_length_q),
    .ctrl_o         (ctrl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (in_accept) begin
      hist_q <= {hist_q[2:0], sample_in};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_valid_q <= 1'b0;
    end else if (in_accept) begin
      win_valid_q <= 1'b1;
    end else if (out_ready) begin
      win_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      win_q      <= {sample_in, hist_q[0], hist_q[1], hist_q[2], hist_q[3]};
      win_ctrl_q <= ctrl;
    end
  end

  brtwo_taps #(
    .SampleW(SampleW)
  ) u_taps (
    .window_i(win_q),
    .kind_i  (win_ctrl_q.kind),
    .value_o (value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= win_valid_q && win_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_advance) begin
      out_value_q <= value;
      out_index_q <= win_ctrl_q.index;
      out_last_q  <= (win_ctrl_q.kind == brtwo_pkg::TAP_LAST_ODD) ||
                     (win_ctrl_q.kind == brtwo_pkg::TAP_LAST_EVEN);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench of the binomial reduce-by-two column filter with a scoreboard class.
`default_nettype none

module tb;

  localparam int unsigned MAX_LEN = brtwo_pkg::DefaultMaxColumn;

  typedef struct {
    logic [brtwo_pkg::OUT_VALUE_W-1:0] value;
    logic [brtwo_pkg::OUT_INDEX_W-1:0] index;
    logic                              last;
  } reduced_sample_t;

  function automatic int unsigned clamp_length(input logic [brtwo_pkg::LENGTH_W-1:0] raw);
    int unsigned len;
    len = 32'(raw);
    if (len < 5) len = 5;
    if (len > MAX_LEN) len = MAX_LEN;
    return len;
  endfunction

  class column_reduce_board;
    logic [brtwo_pkg::LENGTH_W-1:0] length_reg;
    logic [brtwo_pkg::SAMPLE_W-1:0] history[4];
    int unsigned                    next_pos;
    reduced_sample_t                pending_outputs[$];
    int unsigned                    errors;

    function new();
      length_reg = brtwo_pkg::LENGTH_RESET;
      foreach (history[i]) history[i] = '0;
      next_pos = 0;
      errors   = 0;
    endfunction

    function void set_length(input logic [brtwo_pkg::LENGTH_W-1:0] raw);
      length_reg = raw;
    endfunction

    // Works out the reduced sample, if any, that this input transaction completes.
    function void note_sample(input logic [brtwo_pkg::SAMPLE_W-1:0] s);
      int unsigned len, p, last_p, v, idx;
      int unsigned w0, w1, w2, w3, w4;
      bit odd, emit, fin;
      reduced_sample_t want;
      len    = clamp_length(length_reg);
      p      = next_pos;
      last_p = len - 1;
      odd    = (len % 2) == 1;
      w4 = 32'(s);
      w3 = 32'(history[0]);
      w2 = 32'(history[1]);
      w1 = 32'(history[2]);
      w0 = 32'(history[3]);
      emit = 1'b0;
      fin  = 1'b0;
      v    = 0;
      idx  = 0;
      if (p >= last_p) begin
        if (p == last_p) begin
          emit = 1'b1;
          fin  = 1'b1;
          idx  = (len + 1) / 2 - 1;
          if (odd) v = 11 * w4 + 4 * w3 + w2;
          else v = 11 * w3 + 4 * w2 + w1;
        end
      end else if (odd && p == len - 2) begin
        emit = 1'b1;
        idx  = (len + 1) / 2 - 2;
        v    = 5 * w4 + 6 * w3 + 4 * w2 + w1;
      end else if (p == 2) begin
        emit = 1'b1;
        idx  = 0;
        v    = 11 * w2 + 4 * w3 + w4;
      end else if (p >= 4 && (p % 2) == 0 && p <= len - 2) begin
        emit = 1'b1;
        idx  = (p - 2) / 2;
        v    = w0 + 4 * w1 + 6 * w2 + 4 * w3 + w4;
      end
      history[3] = history[2];
      history[2] = history[1];
      history[1] = history[0];
      history[0] = s;
      next_pos = (p >= last_p) ? 0 : p + 1;
      if (emit) begin
        want.value = brtwo_pkg::OUT_VALUE_W'(v);
        want.index = brtwo_pkg::OUT_INDEX_W'(idx);
        want.last  = fin;
        pending_outputs.push_back(want);
      end
    endfunction

    function void check_result(input logic [brtwo_pkg::OUT_VALUE_W-1:0] value,
                               input logic [brtwo_pkg::OUT_INDEX_W-1:0] index,
                               input logic last);
      reduced_sample_t want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0d index %0d last %0b",
                 $time, value, index, last);
        errors++;
        return;
      end
      want = pending_outputs.pop_front();
      if (value !== want.value) begin
        $display("%0t: out_value expected %0d, got %0d", $time, want.value, value);
        errors++;
      end
      if (index !== want.index) begin
        $display("%0t: out_index expected %0d, got %0d", $time, want.index, index);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last expected %0b, got %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              cfg_we;
  logic [brtwo_pkg::LENGTH_W-1:0]    cfg_wdata;
  logic                              in_valid;
  logic                              in_stall;
  logic [brtwo_pkg::SAMPLE_W-1:0]    sample;
  logic                              out_valid;
  logic                              out_stall;
  logic [brtwo_pkg::OUT_VALUE_W-1:0] out_value;
  logic [brtwo_pkg::OUT_INDEX_W-1:0] out_index;
  logic                              out_last;

  column_reduce_board board = new();
  int unsigned        burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  binomial_reduce_by_two uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_value_o (out_value),
    .out_index_o (out_index),
    .out_last_o  (out_last)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [brtwo_pkg::SAMPLE_W-1:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return brtwo_pkg::SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  task automatic send_sample(input logic [brtwo_pkg::SAMPLE_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_sample(value);
  endtask

  // Waits for an empty scoreboard, then idles while the window and result registers clear.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_outputs.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_length(input logic [brtwo_pkg::LENGTH_W-1:0] raw);
    cfg_we    <= 1'b1;
    cfg_wdata <= raw;
    board.set_length(raw);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned received, hold_left, next_hold, run_left, mode;
    received  = 0;
    hold_left = 0;
    next_hold = 150;
    run_left  = 0;
    mode      = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        board.check_result(out_value, out_index, out_last);
        received++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (received >= next_hold) begin
        // Long hold-off so that the block fills up and pushes back on the sender.
        hold_left = 300;
        next_hold = next_hold + 1200;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 3);
          run_left = (mode == 3 && $urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                            : $urandom_range(1, 40);
        end
        run_left--;
        case (mode)
          0: out_stall <= 1'b0;
          3: out_stall <= 1'b1;
          default: out_stall <= ($urandom_range(0, 99) < 30);
        endcase
      end
    end
  end

  initial begin
    int unsigned random_items, n, len_eff, r;
    logic [brtwo_pkg::LENGTH_W-1:0] raw;
    random_items = 0;
    rst_n     = 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    sample    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    repeat (5) send_sample('1);
    drain();
    write_length(brtwo_pkg::LENGTH_W'(6));
    send_sample('0);
    send_sample('1);
    send_sample(16'd1);
    send_sample('0);
    send_sample('1);
    send_sample(16'd1);
    drain();
    write_length(brtwo_pkg::LENGTH_W'(2));
    repeat (3) send_sample(rand_sample());
    drain();
    write_length(brtwo_pkg::LENGTH_W'(9));
    repeat (4) send_sample(rand_sample());
    drain();
    write_length(brtwo_pkg::LENGTH_W'(8));
    send_sample(rand_sample());
    drain();
    write_length(brtwo_pkg::LENGTH_W'(10));
    repeat (6) send_sample(rand_sample());
    drain();
    write_length(brtwo_pkg::LENGTH_W'(6));
    send_sample(rand_sample());

    while (random_items < 1450) begin
      r = $urandom_range(0, 99);
      if (r < 6) raw = brtwo_pkg::LENGTH_W'($urandom_range(0, 4));
      else if (r < 9) raw = brtwo_pkg::LENGTH_W'($urandom_range(4097, 8191));
      else if (r < 75) raw = brtwo_pkg::LENGTH_W'($urandom_range(5, 24));
      else raw = brtwo_pkg::LENGTH_W'($urandom_range(25, 200));
      len_eff = clamp_length(raw);
      n = $urandom_range(1, 3) * len_eff + $urandom_range(0, len_eff - 1);
      if (n > 300) n = $urandom_range(20, 300);
      drain();
      write_length(raw);
      repeat (n) send_sample(rand_sample());
      random_items += n;
    end

    drain();
    write_length('0);
    while (board.next_pos != 0) send_sample(rand_sample());
    drain();
    write_length('1);
    repeat (60) send_sample(rand_sample());
    drain();
    write_length(brtwo_pkg::LENGTH_W'(MAX_LEN));
    repeat (30) send_sample(rand_sample());

    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("tb failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
sv/brtwo_pkg.sv
sv/brtwo_pos.sv
sv/brtwo_taps.sv
sv/binomial_reduce_by_two.sv
tb/sv/tb.sv
